@@ sv/ukf_pkg.sv @@
// Package for the unique-key FIFO: transaction structs, operation and status codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
package ukf_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_SEARCH = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] key;
      logic [15:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] data_out;
      logic [15:0] head_payload;
      logic [4:0]  count;
      logic        is_empty;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] payload;
   } row_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_CMP,
      S_SCAN_WAIT,
      S_POP,
      S_HEAD_WAIT,
      S_HEAD_LOAD,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_next;
      logic       take_match;
      logic       pop;
      logic       load_head;
      logic       finish;
      logic       insert;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic       count_zero;
      logic       count_full;
      logic       key_match;
      logic       scan_last;
      logic [1:0] func;
   } sts_type;

endpackage

@@ sv/ukf_datapath.sv @@
// Datapath of the unique-key FIFO: record memory, head and count registers,
// scan offset and the result register. Depends on ukf_pkg.
module ukf_datapath #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  ukf_pkg::req_type req_data,
   input  ukf_pkg::cmd_type cmd,
   output ukf_pkg::sts_type sts,
   output ukf_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   ukf_pkg::row_type mem [DEPTH];

   ukf_pkg::req_type req_ff, req_in;
   ukf_pkg::row_type rd_ff;
   ukf_pkg::rsp_type rsp_ff, rsp_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    offset_ff, offset_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [15:0]      data_ff, data_in;
   logic [15:0]      head_pl_ff, head_pl_in;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    tail_addr;
   logic [AW-1:0]    head_next;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_A) begin
         s = s - DEPTH_A;
      end
      return s[AW-1:0];
   endfunction

   assign rd_addr   = wrap_add(head_ff, offset_ff);
   assign tail_addr = wrap_add(head_ff, count_ff[AW-1:0]);
   assign head_next = (head_ff == LAST_A) ? '0 : head_ff + AW'(1);

   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff == DEPTH_C);
   assign sts.key_match  = (rd_ff.key == req_ff.key);
   assign sts.scan_last  = ((CW'(offset_ff) + CW'(1)) == count_ff);
   assign sts.func       = req_ff.func;

   assign rsp_data = rsp_ff;

   always_comb begin
      req_in     = req_ff;
      head_in    = head_ff;
      offset_in  = offset_ff;
      count_in   = count_ff;
      data_in    = data_ff;
      head_pl_in = head_pl_ff;
      if (cmd.load_req) begin
         req_in  = req_data;
         data_in = '0;
      end
      if (cmd.scan_next) begin
         offset_in = offset_ff + AW'(1);
      end
      if (cmd.take_match) begin
         data_in = rd_ff.payload;
      end
      if (cmd.pop) begin
         data_in  = rd_ff.payload;
         head_in  = head_next;
         count_in = count_ff - CW'(1);
      end
      if (cmd.load_head) begin
         head_pl_in = rd_ff.payload;
      end
      if (cmd.finish) begin
         offset_in = '0;
         if (cmd.insert) begin
            count_in = count_ff + CW'(1);
            if (count_ff == '0) begin
               head_pl_in = req_ff.payload;
            end
         end
      end
      rsp_in.status       = cmd.status;
      rsp_in.data_out     = data_ff;
      rsp_in.count        = 5'(count_in);
      rsp_in.is_empty     = (count_in == '0);
      rsp_in.head_payload = (count_in == '0) ? 16'd0 : head_pl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         offset_ff <= '0;
         count_ff  <= '0;
      end else begin
         head_ff   <= head_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      data_ff    <= data_in;
      head_pl_ff <= head_pl_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && cmd.insert) begin
         mem[tail_addr] <= '{key: req_ff.key, payload: req_ff.payload};
      end
      rd_ff <= mem[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("Entry count exceeds the queue depth.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.count_zero)
      else $error("Pop issued on an empty queue.");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && cmd.insert) |-> !sts.count_full)
      else $error("Insert committed into a full queue.");

endmodule

@@ sv/ukf_controller.sv @@
// Controller of the unique-key FIFO: sequences insert, remove and search
// transactions and owns the handshake state. Depends on ukf_pkg.
module ukf_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_func,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ukf_pkg::sts_type sts,
   output ukf_pkg::cmd_type cmd
);

   ukf_pkg::state_type state_ff, state_in;
   logic [2:0]         status_ff, status_in;
   logic               ins_ff, ins_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ukf_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      ins_in       = ins_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.status   = status_ff;
      cmd.insert   = ins_ff;
      case (state_ff)
         ukf_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               status_in    = ukf_pkg::ST_OK;
               ins_in       = 1'b0;
               case (req_func)
                  ukf_pkg::FUNC_INSERT: begin
                     if (sts.count_zero) begin
                        ins_in   = 1'b1;
                        state_in = ukf_pkg::S_FINISH;
                     end else begin
                        state_in = ukf_pkg::S_SCAN_CMP;
                     end
                  end
                  ukf_pkg::FUNC_SEARCH: begin
                     if (sts.count_zero) begin
                        status_in = ukf_pkg::ST_NOTFOUND;
                        state_in  = ukf_pkg::S_FINISH;
                     end else begin
                        state_in = ukf_pkg::S_SCAN_CMP;
                     end
                  end
                  ukf_pkg::FUNC_REMOVE: begin
                     if (sts.count_zero) begin
                        status_in = ukf_pkg::ST_EMPTY;
                        state_in  = ukf_pkg::S_FINISH;
                     end else begin
                        state_in = ukf_pkg::S_POP;
                     end
                  end
                  default: begin
                     state_in = ukf_pkg::S_FINISH;
                  end
               endcase
            end
         end
         ukf_pkg::S_SCAN_CMP: begin
            if (sts.key_match) begin
               if (sts.func == ukf_pkg::FUNC_INSERT) begin
                  status_in = ukf_pkg::ST_DUP;
               end else begin
                  cmd.take_match = 1'b1;
               end
               state_in = ukf_pkg::S_FINISH;
            end else if (sts.scan_last) begin
               if (sts.func == ukf_pkg::FUNC_INSERT) begin
                  if (sts.count_full) begin
                     status_in = ukf_pkg::ST_FULL;
                  end else begin
                     ins_in = 1'b1;
                  end
               end else begin
                  status_in = ukf_pkg::ST_NOTFOUND;
               end
               state_in = ukf_pkg::S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ukf_pkg::S_SCAN_WAIT;
            end
         end
         ukf_pkg::S_SCAN_WAIT: begin
            state_in = ukf_pkg::S_SCAN_CMP;
         end
         ukf_pkg::S_POP: begin
            cmd.pop  = 1'b1;
            state_in = ukf_pkg::S_HEAD_WAIT;
         end
         ukf_pkg::S_HEAD_WAIT: begin
            state_in = ukf_pkg::S_HEAD_LOAD;
         end
         ukf_pkg::S_HEAD_LOAD: begin
            cmd.load_head = 1'b1;
            state_in      = ukf_pkg::S_FINISH;
         end
         ukf_pkg::S_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ukf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ukf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ukf_pkg::S_IDLE;
         status_ff    <= ukf_pkg::ST_OK;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         ins_ff       <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ukf_pkg::S_FINISH))
      else $error("Response raised outside the finish step.");

   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ukf_pkg::S_FINISH && ins_ff) |-> (status_ff == ukf_pkg::ST_OK))
      else $error("Insert committed with a failure status.");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("Finished transaction did not present a response.");

endmodule

@@ sv/unique_key_fifo_top.sv @@
// Top level of the unique-key FIFO: joins the controller and the datapath.
// Depends on ukf_pkg, ukf_controller and ukf_datapath.
//
// A bounded FIFO of DEPTH records (32-bit key, 16-bit payload) that refuses duplicate keys;
// every transaction returns one response with status, data, head payload and count. The
// block handles one transaction at a time, and records sit in a simple dual-port memory with
// a registered read, so a key search compares one entry at a time and waits in S_SCAN_WAIT
// before each next compare. An unused code or an operation on an empty queue goes straight
// to S_FINISH; a remove steps through S_POP, S_HEAD_WAIT and S_HEAD_LOAD; an insert or search
// compares at most the count of stored entries. A new transaction is accepted while the
// previous response still waits to be taken; it completes only once that response is taken.
module unique_key_fifo_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ukf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ukf_pkg::rsp_type rsp_data
);

   ukf_pkg::cmd_type cmd;
   ukf_pkg::sts_type sts;

   ukf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ukf_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
